### src/raso_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raso_pkg: shared types and constants for the segment outline block
// Field widths, corner numbering and the per-corner shape table.
// ----------------------------------------------------------------------------
package raso_pkg;

    localparam int IN_COORD_W   = 32;
    localparam int APERTURE_W   = 30;
    localparam int OUT_COORD_W  = 32;
    localparam int CORNER_NUM_W = 3;

    typedef logic [CORNER_NUM_W-1:0] corner_num_t;

    // Steps of the six-corner walk; a zero-length segment skips the third
    // and sixth steps.
    localparam corner_num_t CORNER_FIRST      = 3'd0;
    localparam corner_num_t CORNER_SKIP_A     = 3'd2;
    localparam corner_num_t CORNER_LAST_POINT = 3'd3;
    localparam corner_num_t CORNER_LAST_FLAT  = 3'd4;
    localparam corner_num_t CORNER_LAST       = 3'd5;

    typedef struct packed {
        logic x_hi;
        logic y_hi;
        logic add_delta;
    } corner_shape_t;

    function automatic corner_shape_t corner_shape(corner_num_t step);
        corner_shape_t s;
        s = '0;
        unique case (step)
            3'd0:    s = '{x_hi: 1'b0, y_hi: 1'b0, add_delta: 1'b0};
            3'd1:    s = '{x_hi: 1'b0, y_hi: 1'b1, add_delta: 1'b0};
            3'd2:    s = '{x_hi: 1'b0, y_hi: 1'b1, add_delta: 1'b1};
            3'd3:    s = '{x_hi: 1'b1, y_hi: 1'b1, add_delta: 1'b1};
            3'd4:    s = '{x_hi: 1'b1, y_hi: 1'b0, add_delta: 1'b1};
            3'd5:    s = '{x_hi: 1'b1, y_hi: 1'b0, add_delta: 1'b0};
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

### src/raso_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raso_front: segment intake and classification
// Two stages: endpoint ordering and deltas, then the corner base values.
// ----------------------------------------------------------------------------
module raso_front #(
    parameter int COORD_WIDTH = 32,
    localparam int ENTRY_W = 6 * COORD_WIDTH + 1
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       seg_valid,
    output logic                                       seg_ready,
    input  logic signed [raso_pkg::IN_COORD_W-1:0]     start_x,
    input  logic signed [raso_pkg::IN_COORD_W-1:0]     start_y,
    input  logic signed [raso_pkg::IN_COORD_W-1:0]     end_x,
    input  logic signed [raso_pkg::IN_COORD_W-1:0]     end_y,
    input  logic        [raso_pkg::APERTURE_W-1:0]     aperture_width,
    input  logic        [raso_pkg::APERTURE_W-1:0]     aperture_height,
    output logic                                       q_valid,
    input  logic                                       q_ready,
    output logic        [ENTRY_W-1:0]                  q_data
);

    logic [63:0] sx64, sy64, ex64, ey64, aw64, ah64;
    logic [COORD_WIDTH-1:0] sx, sy, ex, ey;
    logic swap;

    logic                   a_valid_reg;
    logic [COORD_WIDTH-1:0] a_bx_reg, a_by_reg, a_dx_reg, a_dy_reg;
    logic [COORD_WIDTH-1:0] a_hw_reg, a_hh_reg, a_wr_reg, a_hr_reg;
    logic [COORD_WIDTH-1:0] a_bx_next, a_by_next, a_dx_next, a_dy_next;
    logic [COORD_WIDTH-1:0] a_hw_next, a_hh_next, a_wr_next, a_hr_next;

    logic                   b_valid_reg;
    logic [ENTRY_W-1:0]     b_data_reg;
    logic [ENTRY_W-1:0]     b_data_next;
    logic [COORD_WIDTH-1:0] xl, xh, yl, yh;
    logic                   flip, moved;

    logic a_adv, b_adv;

    assign b_adv     = !b_valid_reg || q_ready;
    assign a_adv     = !a_valid_reg || b_adv;
    assign seg_ready = a_adv;

    // stage A: wrap to coordinate width, order endpoints
    assign sx64 = 64'(start_x);
    assign sy64 = 64'(start_y);
    assign ex64 = 64'(end_x);
    assign ey64 = 64'(end_y);
    assign aw64 = 64'(aperture_width);
    assign ah64 = 64'(aperture_height);

    assign sx = sx64[COORD_WIDTH-1:0];
    assign sy = sy64[COORD_WIDTH-1:0];
    assign ex = ex64[COORD_WIDTH-1:0];
    assign ey = ey64[COORD_WIDTH-1:0];

    assign swap = $signed(sx) > $signed(ex);

    always_comb
    begin
        a_bx_next = swap ? ex : sx;
        a_by_next = swap ? ey : sy;
        a_dx_next = swap ? (sx - ex) : (ex - sx);
        a_dy_next = swap ? (sy - ey) : (ey - sy);
        a_hw_next = COORD_WIDTH'(aw64 >> 1);
        a_hh_next = COORD_WIDTH'(ah64 >> 1);
        a_wr_next = COORD_WIDTH'(aw64) - COORD_WIDTH'(aw64 >> 1);
        a_hr_next = COORD_WIDTH'(ah64) - COORD_WIDTH'(ah64 >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_adv)
        begin
            a_valid_reg <= seg_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && seg_valid)
        begin
            a_bx_reg <= a_bx_next;
            a_by_reg <= a_by_next;
            a_dx_reg <= a_dx_next;
            a_dy_reg <= a_dy_next;
            a_hw_reg <= a_hw_next;
            a_hh_reg <= a_hh_next;
            a_wr_reg <= a_wr_next;
            a_hr_reg <= a_hr_next;
        end
    end

    // stage B: flip folded into the y bases; raw dy serves both orientations
    assign flip  = a_dy_reg[COORD_WIDTH-1];
    assign moved = (|a_dx_reg) || (|a_dy_reg);
    assign xl    = a_bx_reg - a_hw_reg;
    assign xh    = a_bx_reg + a_wr_reg;
    assign yl    = flip ? (a_by_reg + a_hh_reg) : (a_by_reg - a_hh_reg);
    assign yh    = flip ? (a_by_reg - a_hr_reg) : (a_by_reg + a_hr_reg);

    assign b_data_next = {moved, xl, xh, yl, yh, a_dx_reg, a_dy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_adv)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv && a_valid_reg)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign q_valid = b_valid_reg;
    assign q_data  = b_data_reg;

endmodule

### src/raso_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raso_queue: short FIFO between classification and corner emission
// Register-based ring with a fill count.
// ----------------------------------------------------------------------------
module raso_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              push, pop;

    assign wr_ready = cnt_reg != CNT_W'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        unique case ({push, pop})
            2'b10:   cnt_next = CNT_W'(cnt_reg + 1'b1);
            2'b01:   cnt_next = CNT_W'(cnt_reg - 1'b1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### src/raso_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raso_back: corner sequencer
// Walks one outline entry corner by corner into a registered output beat.
// ----------------------------------------------------------------------------
module raso_back #(
    parameter int COORD_WIDTH = 32,
    localparam int ENTRY_W = 6 * COORD_WIDTH + 1
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      q_valid,
    output logic                                      q_ready,
    input  logic        [ENTRY_W-1:0]                 q_data,
    output logic                                      corner_valid,
    input  logic                                      corner_ready,
    output logic signed [raso_pkg::OUT_COORD_W-1:0]   corner_x,
    output logic signed [raso_pkg::OUT_COORD_W-1:0]   corner_y,
    output raso_pkg::corner_num_t                     corner_number,
    output logic                                      last_corner
);

    logic                   busy_reg, busy_next;
    raso_pkg::corner_num_t  step_reg, step_next;
    logic                   moved_reg;
    logic [COORD_WIDTH-1:0] xl_reg, xh_reg, yl_reg, yh_reg, dx_reg, dy_reg;

    logic                   out_valid_reg;
    logic [raso_pkg::OUT_COORD_W-1:0] x_reg, y_reg, x_next, y_next;
    raso_pkg::corner_num_t  num_reg, num_next;
    logic                   last_reg, last_next;

    raso_pkg::corner_shape_t shape;
    logic [COORD_WIDTH-1:0] sum_x, sum_y;
    logic [63:0]            ext_x, ext_y;
    logic                   issue, last_step, load;

    assign issue     = busy_reg && (!out_valid_reg || corner_ready);
    assign last_step = moved_reg ? (step_reg == raso_pkg::CORNER_LAST)
                                 : (step_reg == raso_pkg::CORNER_LAST_FLAT);
    assign q_ready   = !busy_reg || (issue && last_step);
    assign load      = q_valid && q_ready;

    assign shape = raso_pkg::corner_shape(step_reg);
    assign sum_x = (shape.x_hi ? xh_reg : xl_reg) + (shape.add_delta ? dx_reg : '0);
    assign sum_y = (shape.y_hi ? yh_reg : yl_reg) + (shape.add_delta ? dy_reg : '0);
    assign ext_x = 64'(signed'(sum_x));
    assign ext_y = 64'(signed'(sum_y));

    always_comb
    begin
        x_next    = ext_x[raso_pkg::OUT_COORD_W-1:0];
        y_next    = ext_y[raso_pkg::OUT_COORD_W-1:0];
        num_next  = (moved_reg || step_reg < raso_pkg::CORNER_SKIP_A)
                    ? step_reg : raso_pkg::corner_num_t'(step_reg - 1'b1);
        last_next = last_step;

        busy_next = busy_reg;
        step_next = step_reg;
        if (issue)
        begin
            if (!moved_reg && raso_pkg::corner_num_t'(step_reg + 1'b1) == raso_pkg::CORNER_SKIP_A)
            begin
                step_next = raso_pkg::corner_num_t'(step_reg + 2'd2);
            end
            else
            begin
                step_next = raso_pkg::corner_num_t'(step_reg + 1'b1);
            end
            if (last_step)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            step_next = raso_pkg::CORNER_FIRST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= raso_pkg::CORNER_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            if (issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (corner_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            {moved_reg, xl_reg, xh_reg, yl_reg, yh_reg, dx_reg, dy_reg} <= q_data;
        end
        if (issue)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            num_reg  <= num_next;
            last_reg <= last_next;
        end
    end

    assign corner_valid  = out_valid_reg;
    assign corner_x      = x_reg;
    assign corner_y      = y_reg;
    assign corner_number = num_reg;
    assign last_corner   = last_reg;

endmodule

### src/rect_aperture_segment_outline.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_aperture_segment_outline: rectangular-aperture segment outline
// Turns a stroked segment into its polygon corners, one beat per corner.
// ----------------------------------------------------------------------------
// A segment beat yields six corner beats, or four when its endpoints
// coincide, numbered from 0 with last_corner set on the final one. The corner
// sequencer emits one corner per cycle while corner_ready is high; that sets
// the sustained rate. Segments are taken back to back through a two-stage
// classifier and a two-entry queue while the sequencer drains; a segment
// passes both classifier stages, the queue and the sequencer entry registers
// before its first corner is output. Coordinate sums wrap at COORD_WIDTH bits.
module rect_aperture_segment_outline #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      seg_valid,
    output logic                                      seg_ready,
    input  logic signed [raso_pkg::IN_COORD_W-1:0]    start_x,
    input  logic signed [raso_pkg::IN_COORD_W-1:0]    start_y,
    input  logic signed [raso_pkg::IN_COORD_W-1:0]    end_x,
    input  logic signed [raso_pkg::IN_COORD_W-1:0]    end_y,
    input  logic        [raso_pkg::APERTURE_W-1:0]    aperture_width,
    input  logic        [raso_pkg::APERTURE_W-1:0]    aperture_height,
    output logic                                      corner_valid,
    input  logic                                      corner_ready,
    output logic signed [raso_pkg::OUT_COORD_W-1:0]   corner_x,
    output logic signed [raso_pkg::OUT_COORD_W-1:0]   corner_y,
    output raso_pkg::corner_num_t                     corner_number,
    output logic                                      last_corner
);

    localparam int ENTRY_W = 6 * COORD_WIDTH + 1;
    localparam int Q_DEPTH = 2;

    logic               fq_valid, fq_ready;
    logic [ENTRY_W-1:0] fq_data;
    logic               qb_valid, qb_ready;
    logic [ENTRY_W-1:0] qb_data;

    raso_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .seg_valid       (seg_valid),
        .seg_ready       (seg_ready),
        .start_x         (start_x),
        .start_y         (start_y),
        .end_x           (end_x),
        .end_y           (end_y),
        .aperture_width  (aperture_width),
        .aperture_height (aperture_height),
        .q_valid         (fq_valid),
        .q_ready         (fq_ready),
        .q_data          (fq_data)
    );

    raso_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (Q_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    raso_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (qb_valid),
        .q_ready       (qb_ready),
        .q_data        (qb_data),
        .corner_valid  (corner_valid),
        .corner_ready  (corner_ready),
        .corner_x      (corner_x),
        .corner_y      (corner_y),
        .corner_number (corner_number),
        .last_corner   (last_corner)
    );

    a_outline_continues: assert property (
        @(posedge clk) disable iff (!rst_n)
        corner_valid && corner_ready && !last_corner |=> corner_valid
    ) else $error("outline gap before last corner");

    a_number_steps: assert property (
        @(posedge clk) disable iff (!rst_n)
        corner_valid && corner_ready && !last_corner |=>
            corner_number == raso_pkg::corner_num_t'($past(corner_number) + 1'b1)
    ) else $error("corner number did not advance by one");

    a_last_count: assert property (
        @(posedge clk) disable iff (!rst_n)
        corner_valid && last_corner |->
            corner_number == raso_pkg::CORNER_LAST_POINT
            || corner_number == raso_pkg::CORNER_LAST
    ) else $error("outline closed after wrong corner count");

    a_restart: assert property (
        @(posedge clk) disable iff (!rst_n)
        corner_valid && corner_ready && last_corner |=>
            !corner_valid || corner_number == raso_pkg::CORNER_FIRST
    ) else $error("new outline did not start at corner zero");

endmodule
